@@ rtl/sat_trail_pkg.sv @@
`default_nettype none
// ============================================================================
// sat_trail_pkg
// Shared types and constants of the SAT assignment trail: command and status
// codes, and the records that move between the front end, the execution
// engine and the result queue.
// ============================================================================
package sat_trail_pkg;

    localparam int MAX_VARS = 1024;
    localparam int VAR_W    = $clog2(MAX_VARS);
    localparam int CNT_W    = VAR_W + 1;
    localparam int LVL_W    = 10;
    localparam int RID_W    = 4;

    localparam logic [LVL_W-1:0] LEVEL_MAX           = {LVL_W{1'b1}};
    localparam logic [RID_W-1:0] FIRST_PROPAGATOR_ID = RID_W'(2);

    typedef enum logic [1:0] {
        CMD_ENQUEUE   = 2'd0,
        CMD_NEW_LEVEL = 2'd1,
        CMD_BACKTRACK = 2'd2,
        CMD_QUERY     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_ASSIGNED = 2'd1,
        STAT_FULL     = 2'd2,
        STAT_RANGE    = 2'd3
    } status_t;

    // Command after decode in the front end
    typedef struct packed {
        cmd_t             op;
        logic [VAR_W-1:0] variable;
        logic             polarity;
        logic [RID_W-1:0] reason_id;
        logic [LVL_W-1:0] backtrack_level;
        logic             in_range;
    } cmd_item_t;

    typedef struct packed {
        status_t          status;
        logic [LVL_W-1:0] current_level;
        logic [CNT_W-1:0] trail_length;
        logic             var_assigned;
        logic             var_value;
        logic [LVL_W-1:0] var_level;
        logic [RID_W-1:0] var_reason_id;
        logic [VAR_W-1:0] var_trail_position;
        logic             var_has_reason_clause;
    } result_t;

    // One trail slot: the variable and the level it was assigned at
    typedef struct packed {
        logic [VAR_W-1:0] variable;
        logic [LVL_W-1:0] level;
    } trail_entry_t;

    typedef struct packed {
        logic [LVL_W-1:0] level;
        logic [RID_W-1:0] reason;
        logic [VAR_W-1:0] pos;
        logic             pol;
    } info_t;

endpackage
`default_nettype wire

@@ rtl/sat_trail_front.sv @@
`default_nettype none
// ============================================================================
// sat_trail_front
// Input side: takes command transactions, decodes them and checks the
// variable range, and holds them in a two-entry queue for the engine.
// ============================================================================
module sat_trail_front
    import sat_trail_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             hold,
    input  logic [CNT_W-1:0] limit,
    input  logic             push,
    output logic             full,
    input  logic [1:0]       command,
    input  logic [VAR_W-1:0] variable,
    input  logic             polarity,
    input  logic [RID_W-1:0] reason_id,
    input  logic [LVL_W-1:0] backtrack_level,
    output logic             item_valid,
    output cmd_item_t        item,
    input  logic             item_pop
);

    cmd_item_t  q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push;
    cmd_item_t  decoded;

    assign full       = hold || (cnt_reg == 2'd2);
    assign do_push    = push && !full;
    assign item_valid = (cnt_reg != 2'd0);
    assign item       = q_reg[rd_ptr_reg];

    always_comb
    begin
        decoded.op              = cmd_t'(command);
        decoded.variable        = variable;
        decoded.polarity        = polarity;
        decoded.reason_id       = reason_id;
        decoded.backtrack_level = backtrack_level;
        decoded.in_range        = ({1'b0, variable} < limit);
    end

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = item_pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(do_push) - 2'(item_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule
`default_nettype wire

@@ rtl/sat_trail_back.sv @@
`default_nettype none
// ============================================================================
// sat_trail_back
// Execution engine: owns the trail, assignment and record memories, runs
// the clearing pass after reset and carries out one command at a time.
// ============================================================================
module sat_trail_back
    import sat_trail_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CNT_W-1:0] limit,
    input  logic             item_valid,
    input  cmd_item_t        item,
    output logic             item_pop,
    input  logic             res_full,
    output logic             res_push,
    output result_t          res,
    output logic             clearing
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_POP_CHK,
        S_POP_WR
    } state_t;

    state_t           state_reg, state_next;
    cmd_item_t        cur_reg;
    logic [LVL_W-1:0] level_reg, level_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [VAR_W-1:0] clr_addr_reg, clr_addr_next;

    // memories
    logic             assign_mem [MAX_VARS];
    trail_entry_t     trail_mem  [MAX_VARS];
    info_t            info_mem   [MAX_VARS];

    logic             asg_we, asg_wdata;
    logic [VAR_W-1:0] asg_waddr, asg_raddr;
    logic             asg_rdata_reg;
    logic             trail_we;
    trail_entry_t     trail_wdata;
    logic [VAR_W-1:0] trail_waddr, trail_raddr_a, trail_raddr_b;
    trail_entry_t     trail_a_rdata_reg, trail_b_rdata_reg;
    logic             info_we;
    info_t            info_wdata;
    logic [VAR_W-1:0] info_waddr, info_raddr;
    info_t            info_rdata_reg;

    logic [CNT_W-1:0] count_m1, count_m2;
    status_t          stat;

    assign clearing = (state_reg == S_CLEAR);
    assign count_m1 = count_reg - CNT_W'(1);
    assign count_m2 = count_reg - CNT_W'(2);

    always_comb
    begin
        state_next    = state_reg;
        level_next    = level_reg;
        count_next    = count_reg;
        clr_addr_next = clr_addr_reg;
        item_pop      = 1'b0;
        res_push      = 1'b0;
        res           = '0;
        stat          = STAT_OK;
        asg_we        = 1'b0;
        asg_waddr     = cur_reg.variable;
        asg_wdata     = 1'b0;
        asg_raddr     = item.variable;
        trail_we      = 1'b0;
        trail_waddr   = count_reg[VAR_W-1:0];
        trail_wdata   = '{variable: cur_reg.variable, level: level_reg};
        trail_raddr_a = count_m1[VAR_W-1:0];
        trail_raddr_b = count_m2[VAR_W-1:0];
        info_we       = 1'b0;
        info_waddr    = cur_reg.variable;
        info_wdata    = '{level: level_reg, reason: cur_reg.reason_id,
                          pos: count_reg[VAR_W-1:0], pol: cur_reg.polarity};
        info_raddr    = item.variable;

        case (state_reg)
            S_CLEAR:
            begin
                asg_we        = 1'b1;
                asg_waddr     = clr_addr_reg;
                clr_addr_next = clr_addr_reg + VAR_W'(1);
                if (clr_addr_reg == VAR_W'(MAX_VARS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (item_valid && !res_full)
                begin
                    item_pop   = 1'b1;
                    state_next = (item.op == CMD_BACKTRACK) ? S_POP_CHK : S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (cur_reg.op)
                    CMD_ENQUEUE:
                    begin
                        if (!cur_reg.in_range)
                        begin
                            stat = STAT_RANGE;
                        end
                        else if (asg_rdata_reg)
                        begin
                            stat = STAT_ASSIGNED;
                        end
                        else if (count_reg >= limit)
                        begin
                            stat = STAT_FULL;
                        end
                        else
                        begin
                            asg_we     = 1'b1;
                            asg_wdata  = 1'b1;
                            trail_we   = 1'b1;
                            info_we    = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    CMD_NEW_LEVEL:
                    begin
                        if (level_reg < LEVEL_MAX)
                        begin
                            level_next = level_reg + LVL_W'(1);
                        end
                    end
                    CMD_QUERY:
                    begin
                        if (!cur_reg.in_range)
                        begin
                            stat = STAT_RANGE;
                        end
                        else
                        begin
                            res.var_assigned          = asg_rdata_reg;
                            res.var_value             = asg_rdata_reg && info_rdata_reg.pol;
                            res.var_level             = info_rdata_reg.level;
                            res.var_reason_id         = info_rdata_reg.reason;
                            res.var_trail_position    = info_rdata_reg.pos;
                            res.var_has_reason_clause =
                                (info_rdata_reg.reason >= FIRST_PROPAGATOR_ID);
                        end
                    end
                    default:
                    begin
                    end
                endcase
                res_push           = 1'b1;
                res.status         = stat;
                res.current_level  = level_next;
                res.trail_length   = count_next;
                state_next         = S_IDLE;
            end
            S_POP_CHK:
            begin
                if ((level_reg > cur_reg.backtrack_level) && (count_reg != '0))
                begin
                    // trail reads for the top two slots are in flight
                    state_next = S_POP_WR;
                end
                else
                begin
                    if (level_reg > cur_reg.backtrack_level)
                    begin
                        level_next = '0;
                    end
                    res_push          = 1'b1;
                    res.status        = STAT_OK;
                    res.current_level = level_next;
                    res.trail_length  = count_reg;
                    state_next        = S_IDLE;
                end
            end
            S_POP_WR:
            begin
                asg_we     = 1'b1;
                asg_waddr  = trail_a_rdata_reg.variable;
                count_next = count_m1;
                level_next = (count_m1 == '0) ? '0 : trail_b_rdata_reg.level;
                state_next = S_POP_CHK;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            level_reg    <= '0;
            count_reg    <= '0;
            clr_addr_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            level_reg    <= level_next;
            count_reg    <= count_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_pop)
        begin
            cur_reg <= item;
        end
    end

    always_ff @(posedge clk)
    begin
        if (asg_we)
        begin
            assign_mem[asg_waddr] <= asg_wdata;
        end
        asg_rdata_reg <= assign_mem[asg_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (trail_we)
        begin
            trail_mem[trail_waddr] <= trail_wdata;
        end
        trail_a_rdata_reg <= trail_mem[trail_raddr_a];
        trail_b_rdata_reg <= trail_mem[trail_raddr_b];
    end

    always_ff @(posedge clk)
    begin
        if (info_we)
        begin
            info_mem[info_waddr] <= info_wdata;
        end
        info_rdata_reg <= info_mem[info_raddr];
    end

endmodule
`default_nettype wire

@@ rtl/sat_trail_resq.sv @@
`default_nettype none
// ============================================================================
// sat_trail_resq
// Result side: two-entry queue that holds finished results until popped.
// ============================================================================
module sat_trail_resq
    import sat_trail_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t res_in,
    output logic    full,
    input  logic    pop,
    output logic    empty,
    output result_t head
);

    result_t    q_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       do_pop;

    assign full   = (cnt_reg == 2'd2);
    assign empty  = (cnt_reg == 2'd0);
    assign do_pop = pop && !empty;
    assign head   = q_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= res_in;
        end
    end

endmodule
`default_nettype wire

@@ rtl/sat_assignment_trail.sv @@
`default_nettype none
// ============================================================================
// sat_assignment_trail
// Assignment trail of a SAT solver: enqueue, new level, backtrack, query.
// ============================================================================
// Commands enter through a queue-style port (push/full) and every command
// gives exactly one result transaction on the result port (empty/pop), in
// order. After reset the block runs a clearing pass over the 1024-entry
// assignment memory, one entry per cycle; full stays high until the pass ends,
// though active_vars can be written over the APB port meanwhile.
// Enqueue, new level and query run in the engine as a registered
// read of the assignment and record memories, then the decision and the
// write. Backtrack pops one literal at a time: each pop reads
// the top two trail slots (the popped variable and the level underneath) and
// then clears the variable's assigned bit. A two-entry command queue in front
// and a two-entry result queue behind let the two sides stall independently.
// active_vars (byte address 0) may only be written while no command is
// pending; values above 1024 act as 1024.
// ============================================================================
module sat_assignment_trail
    import sat_trail_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // command side
    input  logic                 push,
    output logic                 full,
    input  logic [1:0]           command,
    input  logic [VAR_W-1:0]     variable,
    input  logic                 polarity,
    input  logic [RID_W-1:0]     reason_id,
    input  logic [LVL_W-1:0]     backtrack_level,
    // result side
    output logic                 empty,
    input  logic                 pop,
    output logic [1:0]           status,
    output logic [LVL_W-1:0]     current_level,
    output logic [CNT_W-1:0]     trail_length,
    output logic                 var_assigned,
    output logic                 var_value,
    output logic [LVL_W-1:0]     var_level,
    output logic [RID_W-1:0]     var_reason_id,
    output logic [VAR_W-1:0]     var_trail_position,
    output logic                 var_has_reason_clause,
    // APB configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam logic REG_ACTIVE_VARS = 1'b0;

    logic [CNT_W-1:0] active_vars_reg;
    logic [CNT_W-1:0] limit;
    logic             cfg_wr;

    logic             item_valid, item_pop, clearing;
    cmd_item_t        item;
    logic             res_push, res_full;
    result_t          res, head;

    // --- configuration register --------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_ACTIVE_VARS);
    assign prdata = (paddr[2] == REG_ACTIVE_VARS) ? {{(32-CNT_W){1'b0}}, active_vars_reg}
                                                  : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_vars_reg <= CNT_W'(MAX_VARS);
        end
        else if (cfg_wr)
        begin
            active_vars_reg <= pwdata[CNT_W-1:0];
        end
    end

    // effective variable count, clamped to the memory depth
    assign limit = (active_vars_reg > CNT_W'(MAX_VARS)) ? CNT_W'(MAX_VARS)
                                                         : active_vars_reg;

    // --- front end: accept and decode --------------------------------------
    sat_trail_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .hold            (clearing),
        .limit           (limit),
        .push            (push),
        .full            (full),
        .command         (command),
        .variable        (variable),
        .polarity        (polarity),
        .reason_id       (reason_id),
        .backtrack_level (backtrack_level),
        .item_valid      (item_valid),
        .item            (item),
        .item_pop        (item_pop)
    );

    // --- engine ------------------------------------------------------------
    sat_trail_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .limit      (limit),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop),
        .res_full   (res_full),
        .res_push   (res_push),
        .res        (res),
        .clearing   (clearing)
    );

    // --- result queue ------------------------------------------------------
    sat_trail_resq u_resq (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (res_push),
        .res_in (res),
        .full   (res_full),
        .pop    (pop),
        .empty  (empty),
        .head   (head)
    );

    assign status                = head.status;
    assign current_level         = head.current_level;
    assign trail_length          = head.trail_length;
    assign var_assigned          = head.var_assigned;
    assign var_value             = head.var_value;
    assign var_level             = head.var_level;
    assign var_reason_id         = head.var_reason_id;
    assign var_trail_position    = head.var_trail_position;
    assign var_has_reason_clause = head.var_has_reason_clause;

endmodule
`default_nettype wire

@@ rtl/sat_trail_chk.sv @@
`default_nettype none
// ============================================================================
// sat_trail_chk
// Port-level checks of the assignment trail, bound to the top level.
// ============================================================================
module sat_trail_chk
    import sat_trail_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             empty,
    input logic             pop,
    input logic [1:0]       status,
    input logic [CNT_W-1:0] trail_length,
    input logic             var_assigned,
    input logic [LVL_W-1:0] var_level,
    input logic [RID_W-1:0] var_reason_id,
    input logic [VAR_W-1:0] var_trail_position,
    input logic             var_has_reason_clause
);

    // a waiting result holds until it is taken
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(status) && $stable(trail_length))
        else $error("result changed while waiting");

    a_len_max: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> trail_length <= CNT_W'(MAX_VARS))
        else $error("trail length above capacity");

    a_reason_flag: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> var_has_reason_clause == (var_reason_id >= FIRST_PROPAGATOR_ID))
        else $error("reason clause flag mismatch");

    // enqueues rejected as already assigned or full carry no variable record
    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && (status == STAT_ASSIGNED || status == STAT_FULL)
        |-> !var_assigned && var_level == '0 && var_reason_id == '0)
        else $error("variable record on a rejected transaction");

    // an assigned variable sits below the top of the trail
    a_pos_on_trail: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && var_assigned |-> {1'b0, var_trail_position} < trail_length)
        else $error("assigned variable outside the trail");

endmodule

bind sat_assignment_trail sat_trail_chk u_sat_trail_chk (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .empty                 (empty),
    .pop                   (pop),
    .status                (status),
    .trail_length          (trail_length),
    .var_assigned          (var_assigned),
    .var_level             (var_level),
    .var_reason_id         (var_reason_id),
    .var_trail_position    (var_trail_position),
    .var_has_reason_clause (var_has_reason_clause)
);
`default_nettype wire
